// File: hw/rtl/bcdh_pkg.sv
`default_nettype none

package bcdh_pkg;

    // Field and bus widths
    localparam int NOW_W       = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int EVENT_W     = 2;
    localparam int S_TDATA_W   = 40;   // pin_level + now_ms = 33 bits, padded to bytes
    localparam int M_TDATA_W   = 8;    // event_code = 2 bits, padded to a byte

    localparam int TIME_BITS_DEF = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_PRESS_RST     = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd400;
    localparam logic [CFG_W-1:0] HOLD_RST          = 16'd5000;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PRESS     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_WINDOW = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD          = 2'd2;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } t_event;

endpackage

`default_nettype wire

// File: hw/rtl/button_click_double_hold_classifier.sv
// Channel    Dir  Signals                          Content
// s_axis     in   tvalid/tready/tdata[39:0]        poll: pin_level, now_ms
// m_axis     out  tvalid/tready/tdata[7:0]         result: event_code
// cfg        in   we/addr[1:0]/wdata[15:0]         0 min_press, 1 double_window, 2 hold
//
// One poll per cycle sustained while the output is not stalled.
// A poll sits in the input register, is classified in one pass (two parallel
// elapsed-time subtracts and compares) and lands in the result register.
// Synchronous active-low reset clears both valid flags, the button state and
// the registers to their defaults. A stalled output holds its result; the
// input register keeps taking polls as long as the result register drains.
`default_nettype none

module button_click_double_hold_classifier #(
    parameter int TIME_BITS = bcdh_pkg::TIME_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    input  wire logic [bcdh_pkg::S_TDATA_W-1:0] i_s_axis_tdata,

    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [1:0] event_code, [7:2] zero
    output logic [bcdh_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,

    input  wire logic                           i_cfg_we,
    input  wire logic [bcdh_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [bcdh_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import bcdh_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_min_press;
    logic [CFG_W-1:0] r_double_window;
    logic [CFG_W-1:0] r_hold;

    // input stage
    logic                 r_in_valid;
    logic                 r_in_pin;
    logic [TIME_BITS-1:0] r_in_now;
    logic [TIME_BITS-1:0] w_now_cap;

    // output stage
    logic   r_out_valid;
    t_event r_out_event;

    // button state
    logic                 r_pressed_seen, n_pressed_seen;
    logic                 r_hold_fired,   n_hold_fired;
    logic [TIME_BITS-1:0] r_press_start,  n_press_start;
    logic                 r_clicks,       n_clicks;   // only 0 or 1 survives a poll
    logic [TIME_BITS-1:0] r_last_click,   n_last_click;
    logic                 r_click_pending, n_click_pending;
    t_event               n_event;

    logic                 w_advance;
    logic                 w_accept;
    logic                 w_down;
    logic                 w_clicked;
    logic [TIME_BITS-1:0] w_dur;
    logic [TIME_BITS-1:0] w_since_click;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // now_ms zero-extended or truncated to the time width
    assign w_now_cap = TIME_BITS'({32'd0, i_s_axis_tdata[NOW_W:1]});

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-EVENT_W){1'b0}}, r_out_event};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_press     <= MIN_PRESS_RST;
            r_double_window <= DOUBLE_WINDOW_RST;
            r_hold          <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_PRESS:     r_min_press     <= i_cfg_wdata;
                CFG_DOUBLE_WINDOW: r_double_window <= i_cfg_wdata;
                CFG_HOLD:          r_hold          <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_pin <= i_s_axis_tdata[0];
            r_in_now <= w_now_cap;
        end
    end

    assign w_down        = !r_in_pin;
    assign w_dur         = r_in_now - r_press_start;
    assign w_since_click = r_in_now - r_last_click;

    always_comb begin
        n_pressed_seen  = r_pressed_seen;
        n_hold_fired    = r_hold_fired;
        n_press_start   = r_press_start;
        n_clicks        = r_clicks;
        n_last_click    = r_last_click;
        n_click_pending = r_click_pending;
        n_event         = EV_NONE;
        w_clicked       = 1'b0;

        if (w_down && !r_pressed_seen && !r_hold_fired) begin
            n_pressed_seen = 1'b1;
            n_press_start  = r_in_now;
        end else if (!w_down && r_pressed_seen) begin
            n_pressed_seen = 1'b0;
            n_hold_fired   = 1'b0;
            if (w_dur > TIME_BITS'(r_min_press) && w_dur < TIME_BITS'(r_hold)) begin
                w_clicked    = 1'b1;
                n_last_click = r_in_now;
                if (r_clicks) begin
                    n_clicks        = 1'b0;
                    n_click_pending = 1'b0;
                    n_event         = EV_DOUBLE;
                end else begin
                    n_clicks        = 1'b1;
                    n_click_pending = 1'b1;
                end
            end
        end else if (w_down && r_pressed_seen && !r_hold_fired) begin
            if (w_dur >= TIME_BITS'(r_hold)) begin
                n_hold_fired    = 1'b1;
                n_click_pending = 1'b0;
                n_clicks        = 1'b0;
                n_event         = EV_HOLD;
            end
        end

        // a click counted on this poll is excluded by !w_clicked, so it never times out here
        if (n_event == EV_NONE && n_click_pending && !w_clicked
                && w_since_click > TIME_BITS'(r_double_window)) begin
            n_click_pending = 1'b0;
            n_clicks        = 1'b0;
            n_event         = EV_CLICK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_seen  <= 1'b0;
            r_hold_fired    <= 1'b0;
            r_press_start   <= '0;
            r_clicks        <= 1'b0;
            r_last_click    <= '0;
            r_click_pending <= 1'b0;
        end else if (w_advance) begin
            r_pressed_seen  <= n_pressed_seen;
            r_hold_fired    <= n_hold_fired;
            r_press_start   <= n_press_start;
            r_clicks        <= n_clicks;
            r_last_click    <= n_last_click;
            r_click_pending <= n_click_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_event <= n_event;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bcdh_checker.sv
`default_nettype none

module bcdh_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_axis_tvalid,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [bcdh_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    // stalled result stays offered
    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its code
    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // first cycle out of reset: empty and ready
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("pipeline not empty after reset");

    // a poll taken last cycle fills the input stage, so a full stalled pipe refuses more
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_s_axis_tvalid && o_s_axis_tready)
            && o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("poll accepted with both stages full and output stalled");

endmodule

bind button_click_double_hold_classifier bcdh_checker u_bcdh_checker (.*);

`default_nettype wire
